### rtl/nfba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_pkg: shared types and constants of the next-fit block allocator
// Operation codes, fixed field widths, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package nfba_pkg;

	localparam int INDEX_BITS   = 6;
	localparam int IN_SIZE_BITS = 16;
	localparam int COUNT_BITS   = 7;
	localparam int TOTAL_BITS   = 22;

	localparam logic [COUNT_BITS-1:0] BLOCK_COUNT_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic capture;
		logic clr_start;
		logic clr_step;
		logic load_wr;
		logic scan_start;
		logic scan_step;
		logic grant;
		logic finish_null;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_hit;
		logic scan_miss;
	} status_t;

endpackage
`default_nettype wire

### rtl/nfba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_ctrl: allocator controller
// Sequences the table sweep, load, scan and grant steps of one request.
// ----------------------------------------------------------------------------
module nfba_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       op,
	input  wire nfba_pkg::status_t sts,
	output nfba_pkg::cmd_t        cmd,
	output logic                  busy
);

	nfba_pkg::state_t st_q;
	nfba_pkg::state_t st_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= nfba_pkg::ST_INIT;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_comb begin
		cmd    = '0;
		st_nxt = st_q;
		case (st_q)
			nfba_pkg::ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					st_nxt = nfba_pkg::ST_IDLE;
				end
			end
			nfba_pkg::ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					case (op)
						nfba_pkg::OP_LOAD: begin
							st_nxt = nfba_pkg::ST_LOAD_RD;
						end
						nfba_pkg::OP_ALLOC: begin
							cmd.scan_start = 1'b1;
							st_nxt         = nfba_pkg::ST_SCAN;
						end
						nfba_pkg::OP_CLEAR: begin
							cmd.clr_start = 1'b1;
							st_nxt        = nfba_pkg::ST_CLEAR;
						end
						default: begin
							cmd.finish_null = 1'b1;
						end
					endcase
				end
			end
			nfba_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.finish_null = 1'b1;
					st_nxt          = nfba_pkg::ST_IDLE;
				end
			end
			nfba_pkg::ST_LOAD_RD: begin
				st_nxt = nfba_pkg::ST_LOAD_WR;
			end
			nfba_pkg::ST_LOAD_WR: begin
				cmd.load_wr = 1'b1;
				st_nxt      = nfba_pkg::ST_IDLE;
			end
			nfba_pkg::ST_SCAN: begin
				if (sts.scan_hit) begin
					cmd.grant = 1'b1;
					st_nxt    = nfba_pkg::ST_IDLE;
				end else if (sts.scan_miss) begin
					cmd.finish_null = 1'b1;
					st_nxt          = nfba_pkg::ST_IDLE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			default: begin
				st_nxt = nfba_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (st_q != nfba_pkg::ST_IDLE);

endmodule
`default_nettype wire

### rtl/nfba_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfba_dpath: allocator datapath
// Block table memory, scan pointer and read stage, totals and result registers.
// ----------------------------------------------------------------------------
module nfba_dpath #(
	parameter int MAX_BLOCKS = 64,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire nfba_pkg::cmd_t                      cmd,
	output nfba_pkg::status_t                        sts,
	input  wire logic [nfba_pkg::INDEX_BITS-1:0]     block_index,
	input  wire logic [nfba_pkg::IN_SIZE_BITS-1:0]   size,
	input  wire logic                                cfg_wr_en,
	input  wire logic [nfba_pkg::COUNT_BITS-1:0]     cfg_wr_data,
	output logic                                     done,
	output logic                                     found,
	output logic [nfba_pkg::INDEX_BITS-1:0]          granted_block,
	output logic [nfba_pkg::IN_SIZE_BITS-1:0]        leftover,
	output logic [nfba_pkg::TOTAL_BITS-1:0]          internal_total,
	output logic [nfba_pkg::TOTAL_BITS-1:0]          external_total
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int NW = (CW > nfba_pkg::COUNT_BITS) ? CW : nfba_pkg::COUNT_BITS;
	localparam int IW = (CW > nfba_pkg::INDEX_BITS) ? CW : nfba_pkg::INDEX_BITS;
	localparam int WW = 2 * SIZE_BITS + 1;
	localparam int TW = nfba_pkg::TOTAL_BITS;

	// table word: used mark, leftover, block size
	logic [WW-1:0] mem [MAX_BLOCKS];
	logic [WW-1:0] rdata_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [WW-1:0] wr_data;
	logic          wr_en;

	logic [nfba_pkg::COUNT_BITS-1:0] block_count_q;
	logic [IW-1:0]                   idx_q;
	logic [SIZE_BITS-1:0]            sz_q;
	logic [AW-1:0]                   clr_addr_q;
	logic [CW-1:0]                   search_start_q;
	logic [TW-1:0]                   internal_q;
	logic [TW-1:0]                   external_q;
	logic [CW-1:0]                   scan_addr_q;
	logic [CW-1:0]                   scan_left_q;
	logic [CW-1:0]                   scan_n_q;
	logic [AW-1:0]                   idx_s1;
	logic                            v_s1;
	logic                            done_q;
	logic                            found_q;
	logic [nfba_pkg::INDEX_BITS-1:0] granted_q;
	logic [nfba_pkg::IN_SIZE_BITS-1:0] leftover_q;

	logic [SIZE_BITS-1:0] size_rd;
	logic [SIZE_BITS-1:0] left_rd;
	logic                 used_rd;
	logic [SIZE_BITS-1:0] left_hit;
	logic [NW-1:0]        bc_wide;
	logic [CW-1:0]        n_eff;
	logic [CW-1:0]        scan_first;
	logic [CW-1:0]        scan_inc;
	logic                 load_ok;
	logic                 issue;

	assign size_rd  = rdata_q[SIZE_BITS-1:0];
	assign left_rd  = rdata_q[2*SIZE_BITS-1:SIZE_BITS];
	assign used_rd  = rdata_q[2*SIZE_BITS];
	assign left_hit = size_rd - sz_q;

	// participating blocks saturate at the table depth
	assign bc_wide    = NW'(block_count_q);
	assign n_eff      = (bc_wide > NW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(bc_wide);
	assign scan_first = (search_start_q < n_eff) ? search_start_q : '0;
	assign scan_inc   = scan_addr_q + CW'(1);
	assign load_ok    = (idx_q < IW'(MAX_BLOCKS));
	assign issue      = cmd.scan_step && (scan_left_q != '0);

	assign sts.clr_last  = (clr_addr_q == AW'(MAX_BLOCKS - 1));
	assign sts.scan_hit  = v_s1 && !used_rd && (sz_q <= size_rd);
	assign sts.scan_miss = !v_s1 && (scan_left_q == '0);

	assign rd_addr = cmd.scan_step ? scan_addr_q[AW-1:0] : idx_q[AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = {1'b0, {SIZE_BITS{1'b0}}, sz_q};
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (cmd.grant) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1;
			wr_data = {1'b1, left_hit, size_rd};
		end else if (cmd.load_wr && load_ok) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// request capture and scan stage registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= IW'(block_index);
			sz_q  <= SIZE_BITS'(size);
		end
		if (issue) begin
			idx_s1 <= scan_addr_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q  <= nfba_pkg::BLOCK_COUNT_RESET;
			clr_addr_q     <= '0;
			search_start_q <= '0;
			internal_q     <= '0;
			external_q     <= '0;
			scan_addr_q    <= '0;
			scan_left_q    <= '0;
			scan_n_q       <= '0;
			v_s1           <= 1'b0;
			done_q         <= 1'b0;
			found_q        <= 1'b0;
			granted_q      <= '0;
			leftover_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				block_count_q <= cfg_wr_data;
			end

			if (cmd.clr_step) begin
				clr_addr_q <= sts.clr_last ? '0 : clr_addr_q + AW'(1);
			end

			v_s1 <= issue;
			if (cmd.scan_start) begin
				scan_addr_q <= scan_first;
				scan_left_q <= n_eff;
				scan_n_q    <= n_eff;
			end else if (issue) begin
				scan_addr_q <= (scan_inc == scan_n_q) ? '0 : scan_inc;
				scan_left_q <= scan_left_q - CW'(1);
			end

			if (cmd.clr_start) begin
				search_start_q <= '0;
				internal_q     <= '0;
				external_q     <= '0;
			end else if (cmd.load_wr && load_ok) begin
				if (used_rd) begin
					internal_q <= internal_q - TW'(left_rd);
					external_q <= external_q + TW'(sz_q);
				end else begin
					external_q <= external_q - TW'(size_rd) + TW'(sz_q);
				end
			end else if (cmd.grant) begin
				internal_q     <= internal_q + TW'(left_hit);
				external_q     <= external_q - TW'(size_rd);
				search_start_q <= CW'(idx_s1) + CW'(1);
			end

			done_q <= cmd.grant || cmd.finish_null || cmd.load_wr;
			if (cmd.grant) begin
				found_q    <= 1'b1;
				granted_q  <= nfba_pkg::INDEX_BITS'(idx_s1);
				leftover_q <= nfba_pkg::IN_SIZE_BITS'(left_hit);
			end else if (cmd.finish_null || cmd.load_wr) begin
				found_q    <= 1'b0;
				granted_q  <= '0;
				leftover_q <= '0;
			end
		end
	end

	assign done           = done_q;
	assign found          = found_q;
	assign granted_block  = granted_q;
	assign leftover       = leftover_q;
	assign internal_total = internal_q;
	assign external_total = external_q;

endmodule
`default_nettype wire

### rtl/next_fit_block_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_block_allocator_top: next-fit allocator over a table of blocks
// Usage:
//  - A request (op, block_index, size) is taken at a clock edge with start
//    high and busy low. op selects load of a block size, allocate, or clear.
//  - Every request produces one result: done is high for exactly one cycle
//    and found, granted_block, leftover, internal_total and external_total
//    hold the answer in that cycle. The receiver cannot stall the block.
//  - An allocate ends at the first hit or, on a miss, once all searched
//    blocks are read; the scan reads one table entry per cycle from a
//    single read port of the block table.
//  - The block takes one request at a time; busy is low again in the done
//    cycle, so the next request may be accepted there.
//  - cfg_wr_en / cfg_wr_data write block_count at any edge; write it only
//    while the block is idle.
//  - After reset the block sweeps every table entry to zero with busy
//    high; configuration writes are still taken then. Totals and the
//    search pointer are cleared at once, block_count resets to 64.
// ----------------------------------------------------------------------------
module next_fit_block_allocator_top #(
	parameter int MAX_BLOCKS = 64,
	parameter int SIZE_BITS  = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        op,
	input  wire logic [nfba_pkg::INDEX_BITS-1:0]   block_index,
	input  wire logic [nfba_pkg::IN_SIZE_BITS-1:0] size,
	input  wire logic                              cfg_wr_en,
	input  wire logic [nfba_pkg::COUNT_BITS-1:0]   cfg_wr_data,
	output logic                                   done,
	output logic                                   found,
	output logic [nfba_pkg::INDEX_BITS-1:0]        granted_block,
	output logic [nfba_pkg::IN_SIZE_BITS-1:0]      leftover,
	output logic [nfba_pkg::TOTAL_BITS-1:0]        internal_total,
	output logic [nfba_pkg::TOTAL_BITS-1:0]        external_total
);

	// command and status between the sequencer and the table datapath
	nfba_pkg::cmd_t    cmd;
	nfba_pkg::status_t sts;

	// sequence sweep, load, scan and grant steps
	nfba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// hold the block table, scan pointer, totals and result registers
	nfba_dpath #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.block_index    (block_index),
		.size           (size),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.done           (done),
		.found          (found),
		.granted_block  (granted_block),
		.leftover       (leftover),
		.internal_total (internal_total),
		.external_total (external_total)
	);

endmodule
`default_nettype wire
